>>> hdl/fpcc_pkg.sv
// ----------------------------------------------------------------------------
// Framed packet checker package
// Shared widths, header layout constants, result type and the CRC byte step.
// ----------------------------------------------------------------------------
`default_nettype none

package fpcc_pkg;

  localparam int unsigned CountW = 19;
  localparam int unsigned LenW   = 19;

  localparam logic [CountW-1:0] CountMax     = 19'h7ffff;
  localparam logic [CountW-1:0] HdrLen       = 19'd48;
  localparam logic [CountW-1:0] MagicLen     = 19'd4;
  localparam logic [CountW-1:0] CrcSkipStart = 19'd44;
  localparam logic [CountW-1:0] VersionEnd   = 19'd7;
  localparam logic [CountW-1:0] HdrLenEnd    = 19'd11;
  localparam logic [CountW-1:0] FlagsEnd     = 19'd15;
  localparam logic [CountW-1:0] PayloadEnd   = 19'd43;
  localparam logic [CountW-1:0] CrcWordEnd   = 19'd47;

  localparam logic [LenW-1:0] MaxPayloadReset = 19'd262144;

  localparam logic [31:0] CrcPoly   = 32'hedb88320;
  localparam logic [31:0] AllOnes   = 32'hffffffff;
  localparam logic [31:0] FlagMask  = 32'hffff0000;
  localparam logic [31:0] MagicWord = 32'h3153504b;

  localparam logic [15:0] VersionOne = 16'd1;

  typedef struct packed {
    logic push;
    logic ok;
  } fpcc_result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] crc;
    crc = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      crc = (crc >> 1) ^ (crc[0] ? CrcPoly : 32'd0);
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

>>> hdl/fpcc_if.sv
// ----------------------------------------------------------------------------
// Framed packet checker channels
// Valid/ready interfaces for the byte stream, the results and the config write.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpcc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_frame;

  modport source (output valid, output data_byte, output end_of_frame, input ready);
  modport sink (input valid, input data_byte, input end_of_frame, output ready);
endinterface

interface fpcc_result_if;
  logic valid;
  logic ready;
  logic frame_ok;

  modport source (output valid, output frame_ok, input ready);
  modport sink (input valid, input frame_ok, output ready);
endinterface

interface fpcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [18:0] max_payload_len;

  modport source (output valid, output max_payload_len, input ready);
  modport sink (input valid, input max_payload_len, output ready);
endinterface

`default_nettype wire

>>> hdl/fpcc_frame_check.sv
// ----------------------------------------------------------------------------
// Framed packet frame checker
// Per-byte header field checks, length tracking and CRC-32 over the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module fpcc_frame_check
  import fpcc_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            end_of_frame_i,
  input  wire logic [LenW-1:0] max_payload_len_i,
  output fpcc_result_t         result_o
);

  logic [CountW-1:0] count_q, count_d;
  logic [31:0]       crc_q, crc_d;
  logic              fault_q, fault_d;
  logic [31:0]       gather_q, gather_d;
  logic [31:0]       plen_q, plen_d;
  logic [31:0]       check_q, check_d;
  logic              long_q, long_d;
  logic [CountW:0]   frame_len;
  logic [32:0]       need_len;
  logic [7:0]        magic_byte;

  always_comb begin
    long_d   = long_q | (count_q == CountMax);
    fault_d  = fault_q;
    gather_d = {data_byte_i, gather_q[31:8]};
    plen_d   = plen_q;
    check_d  = check_q;
    magic_byte = MagicWord[{count_q[1:0], 3'b000} +: 8];
    if ((count_q < MagicLen) && (data_byte_i != magic_byte)) begin
      fault_d = 1'b1;
    end
    case (count_q)
      VersionEnd: begin
        if ((gather_d[15:0] != VersionOne) || (gather_d[31:16] != 16'd0)) begin
          fault_d = 1'b1;
        end
      end
      HdrLenEnd: begin
        if ((gather_d[15:0] != 16'(HdrLen)) || (gather_d[31:16] == 16'd0)) begin
          fault_d = 1'b1;
        end
      end
      FlagsEnd: begin
        if ((gather_d & FlagMask) != 32'd0) begin
          fault_d = 1'b1;
        end
      end
      PayloadEnd: plen_d  = gather_d;
      CrcWordEnd: check_d = gather_d;
      default: ;
    endcase
    if ((count_q < CrcSkipStart) || (count_q >= HdrLen)) begin
      crc_d = crc_byte(crc_q, data_byte_i);
    end else begin
      crc_d = crc_q;
    end
    count_d = (count_q < CountMax) ? (count_q + 1'b1) : count_q;
  end

  assign frame_len = {1'b0, count_q} + 1'b1;
  assign need_len  = {14'd0, HdrLen} + {1'b0, plen_d};

  assign result_o.push = accept_i & end_of_frame_i;
  assign result_o.ok   = !long_d && !fault_d
                      && (frame_len >= {1'b0, HdrLen})
                      && (plen_d <= {13'd0, max_payload_len_i})
                      && ({13'd0, frame_len} == need_len)
                      && ((crc_d ^ AllOnes) == check_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      crc_q    <= AllOnes;
      fault_q  <= 1'b0;
      gather_q <= '0;
      plen_q   <= '0;
      check_q  <= '0;
      long_q   <= 1'b0;
    end else if (accept_i) begin
      if (end_of_frame_i) begin
        count_q  <= '0;
        crc_q    <= AllOnes;
        fault_q  <= 1'b0;
        gather_q <= '0;
        plen_q   <= '0;
        check_q  <= '0;
        long_q   <= 1'b0;
      end else begin
        count_q  <= count_d;
        crc_q    <= crc_d;
        fault_q  <= fault_d;
        gather_q <= gather_d;
        plen_q   <= plen_d;
        check_q  <= check_d;
        long_q   <= long_d;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/framed_packet_header_crc_checker.sv
// ----------------------------------------------------------------------------
// Framed packet header and CRC checker
// Bytes enter on in_i, one transfer per byte, end_of_frame on the last one.
// Each frame gives one transfer on out_o with frame_ok set when the 48-byte
// header fields, the declared payload length and the CRC-32 all check.
// cfg_i writes max_payload_len; its ready is always high.
// Throughput is one byte per clock while in_i.ready is high; the eight-bit
// CRC step and the header field checks are combinational off the frame state
// registers. A result enters the output queue on its last byte's transfer.
// Results go through a two-entry output queue, so bytes keep flowing while
// a result waits; in_i.ready drops only when both entries are occupied.
// Reset clears the frame state and the queue and sets max_payload_len
// to 262144.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_packet_header_crc_checker
  import fpcc_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  fpcc_byte_if.sink     in_i,
  fpcc_result_if.source out_o,
  fpcc_cfg_if.sink      cfg_i
);

  logic [LenW-1:0] max_len_q;
  logic            head_v_q, head_ok_q;
  logic            skid_v_q, skid_ok_q;
  logic            accept;
  logic            pop;
  fpcc_result_t    result;

  assign in_i.ready  = !skid_v_q;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid & in_i.ready;
  assign pop         = head_v_q & out_o.ready;

  assign out_o.valid    = head_v_q;
  assign out_o.frame_ok = head_ok_q;

  fpcc_frame_check u_frame_check (
    .clk_i,
    .rst_ni,
    .accept_i          (accept),
    .data_byte_i       (in_i.data_byte),
    .end_of_frame_i    (in_i.end_of_frame),
    .max_payload_len_i (max_len_q),
    .result_o          (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxPayloadReset;
    end else if (cfg_i.valid) begin
      max_len_q <= cfg_i.max_payload_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop) begin
      head_v_q <= skid_v_q | result.push;
      skid_v_q <= skid_v_q & result.push;
    end else if (result.push) begin
      head_v_q <= 1'b1;
      skid_v_q <= head_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      head_ok_q <= skid_v_q ? skid_ok_q : result.ok;
      if (skid_v_q && result.push) begin
        skid_ok_q <= result.ok;
      end
    end else if (result.push) begin
      if (head_v_q) begin
        skid_ok_q <= result.ok;
      end else begin
        head_ok_q <= result.ok;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/fpcc_checker.sv
// ----------------------------------------------------------------------------
// Framed packet checker assertions
// Port-level checks on result ordering and backpressure, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module fpcc_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic in_eof_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic out_ok_i,
  input wire logic cfg_ready_i
);

  logic in_last_xfer;

  assign in_last_xfer = in_valid_i & in_ready_i & in_eof_i;

  a_result_needs_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_last_xfer))
    else $error("result appeared without a last-byte transfer");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled while no result is pending");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_ok_i))
    else $error("pending result changed before its transfer");

  a_cfg_always_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("config port not ready");

endmodule

bind framed_packet_header_crc_checker fpcc_checker u_fpcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_eof_i    (in_i.end_of_frame),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_ok_i    (out_o.frame_ok),
  .cfg_ready_i (cfg_i.ready)
);

`default_nettype wire
